### rtl/dlf_pkg.sv
// ----------------------------------------------------------------------------
// Delimited line framer package
// Shared sizes, result kind codes and configuration register indexes.
// ----------------------------------------------------------------------------
package dlf_pkg;

  localparam int LINE_BYTES  = 64;
  localparam int BYTE_W      = 8;
  localparam int ADDR_W      = $clog2(LINE_BYTES);
  localparam int FILL_W      = $clog2(LINE_BYTES + 1);
  localparam int CFG_INDEX_W = 1;

  localparam logic [BYTE_W-1:0] END_MARKER_A_RESET = BYTE_W'(10);
  localparam logic [BYTE_W-1:0] END_MARKER_B_RESET = BYTE_W'(13);

  typedef enum logic {
    KIND_LINE_BYTE = 1'b0,
    KIND_DISCARD   = 1'b1
  } result_kind_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_END_MARKER_A = CFG_INDEX_W'(0),
    CFG_END_MARKER_B = CFG_INDEX_W'(1)
  } cfg_index_t;

endpackage

### rtl/dlf_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module dlf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/dlf_cfg.sv
// ----------------------------------------------------------------------------
// Line framer configuration
// Holds the two end marker registers and flags a byte that matches either.
// ----------------------------------------------------------------------------
module dlf_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  input  logic [dlf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [dlf_pkg::BYTE_W-1:0]       cfg_data,
  input  logic [dlf_pkg::BYTE_W-1:0]       probe_byte,
  output logic                             is_marker
);
  import dlf_pkg::*;

  logic [BYTE_W-1:0] end_marker_a;
  logic [BYTE_W-1:0] end_marker_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      end_marker_a <= END_MARKER_A_RESET;
      end_marker_b <= END_MARKER_B_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_END_MARKER_A: end_marker_a <= cfg_data;
        CFG_END_MARKER_B: end_marker_b <= cfg_data;
        default: ;
      endcase
    end
  end

  assign is_marker = (probe_byte == end_marker_a) || (probe_byte == end_marker_b);

endmodule

### rtl/delimited_line_framer_core.sv
// ----------------------------------------------------------------------------
// Delimited line framer core
// Collects received bytes into a line store and emits each finished line.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while no line is being emitted. A byte that
// matches either end marker closes the line: a clean line of n bytes is then
// read out of the line RAM and presented one byte per cycle while the
// receiver keeps up, and the input is held off meanwhile (the read setup state
// S_READ, then S_LOAD through the registered read port). An overflowed line
// produces a single discard transfer and holds the input off until that
// transfer enters the output register. A receiver that holds off stretches
// either hold-off for as long as it stalls. The output register lets the
// next byte be taken while the last result of a line still waits.
// The line RAM needs no clearing after reset; configuration writes are always
// taken and should be done while the block is idle.
// ----------------------------------------------------------------------------
module delimited_line_framer_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [dlf_pkg::BYTE_W-1:0]       rx_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             result_kind,
  output logic [dlf_pkg::BYTE_W-1:0]       line_byte,
  output logic [dlf_pkg::FILL_W-1:0]       line_length,
  output logic                             end_of_run,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [dlf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [dlf_pkg::BYTE_W-1:0]       cfg_data
);
  import dlf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_LOAD = 4'b0100,
    S_DROP = 4'b1000
  } state_t;

  state_t              state;
  logic [FILL_W-1:0]   fill;
  logic                overflow;
  logic [FILL_W-1:0]   len;
  logic [ADDR_W-1:0]   rd_idx;

  logic                accept;
  logic                room;
  logic                is_marker;
  logic                overflow_now;
  logic                slot_free;
  logic                out_load;
  logic                rd_last;
  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  logic [BYTE_W-1:0]   rd_data;

  assign cfg_ready    = 1'b1;
  assign in_ready     = (state == S_IDLE);
  assign accept       = in_valid && in_ready;
  assign room         = (fill < FILL_W'(LINE_BYTES));
  assign overflow_now = overflow || !room;
  assign slot_free    = !out_valid || out_ready;
  assign out_load     = ((state == S_LOAD) || (state == S_DROP)) && slot_free;
  assign rd_last      = ((FILL_W'(rd_idx) + FILL_W'(1)) == len);

  // The next byte's read is issued in the same cycle the current one moves
  // to the output register: one byte a cycle while the receiver keeps up.
  assign rd_en   = (state == S_READ) || ((state == S_LOAD) && slot_free && !rd_last);
  assign rd_addr = (state == S_READ) ? rd_idx : rd_idx + ADDR_W'(1);

  dlf_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .probe_byte (rx_byte),
    .is_marker  (is_marker)
  );

  dlf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (LINE_BYTES)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (accept && room),
    .wr_addr (fill[ADDR_W-1:0]),
    .wr_data (rx_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      overflow  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (is_marker) begin
              len      <= room ? fill + FILL_W'(1) : fill;
              rd_idx   <= '0;
              fill     <= '0;
              overflow <= 1'b0;
              state    <= overflow_now ? S_DROP : S_READ;
            end else if (room) begin
              fill <= fill + FILL_W'(1);
            end else begin
              overflow <= 1'b1;
            end
          end
        end
        S_READ: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          if (slot_free) begin
            out_valid   <= 1'b1;
            result_kind <= KIND_LINE_BYTE;
            line_byte   <= rd_data;
            line_length <= len;
            end_of_run  <= rd_last;
            if (rd_last) begin
              state <= S_IDLE;
            end else begin
              rd_idx <= rd_idx + ADDR_W'(1);
            end
          end
        end
        S_DROP: begin
          if (slot_free) begin
            out_valid   <= 1'b1;
            result_kind <= KIND_DISCARD;
            line_byte   <= '0;
            line_length <= len;
            end_of_run  <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
